// ----- rtl/sha1_pkg.sv -----
// Shared types and constants of the SHA-1 hash engine.
package sha1_pkg;

    // Working variables of one compression
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } sha1_vars_t;

    // Initial hash value, element 0 is H0
    localparam logic [4:0][31:0] HASH_IV = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    // Round constants, one for each group of twenty rounds
    localparam logic [31:0] K_ROUND0 = 32'h5a827999;
    localparam logic [31:0] K_ROUND1 = 32'h6ed9eba1;
    localparam logic [31:0] K_ROUND2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_ROUND3 = 32'hca62c1d6;

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [7:0] PAD_MARK   = 8'h80;

endpackage

// ----- rtl/sha1_round.sv -----
// One SHA-1 round: the shared compression unit, reused for all 80 rounds.
module sha1_round (
    input  sha1_pkg::sha1_vars_t vars_in,
    input  logic [31:0]          w,
    input  logic [6:0]           round_idx,
    output sha1_pkg::sha1_vars_t vars_out
);

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] temp;

    // Select the round function and constant by round group
    always_comb
    begin
        if (round_idx < 7'd20)
        begin
            f = (vars_in.b & vars_in.c) | (~vars_in.b & vars_in.d);
            k = sha1_pkg::K_ROUND0;
        end
        else if (round_idx < 7'd40)
        begin
            f = vars_in.b ^ vars_in.c ^ vars_in.d;
            k = sha1_pkg::K_ROUND1;
        end
        else if (round_idx < 7'd60)
        begin
            f = (vars_in.b & vars_in.c) | (vars_in.b & vars_in.d) | (vars_in.c & vars_in.d);
            k = sha1_pkg::K_ROUND2;
        end
        else
        begin
            f = vars_in.b ^ vars_in.c ^ vars_in.d;
            k = sha1_pkg::K_ROUND3;
        end
    end

    assign temp = {vars_in.a[26:0], vars_in.a[31:27]} + f + vars_in.e + k + w;

    // Rotate the working variables
    always_comb
    begin
        vars_out.a = temp;
        vars_out.b = vars_in.a;
        vars_out.c = {vars_in.b[1:0], vars_in.b[31:2]};
        vars_out.d = vars_in.c;
        vars_out.e = vars_in.d;
    end

endmodule

// ----- rtl/sha1_sched.sv -----
// Byte packer and message schedule window of the SHA-1 engine.
module sha1_sched (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,       // one byte into the block
    input  logic [7:0]  push_byte,
    input  logic [1:0]  byte_lane,  // byte position within the word, 0 is MSB
    input  logic        step,       // advance one round
    output logic [31:0] w
);

    logic [23:0] acc_reg;
    logic [31:0] win_reg [16];
    logic [31:0] mix;
    logic [31:0] sched_word;

    // Next schedule word from the fixed taps
    assign mix        = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign sched_word = {mix[30:0], mix[31]};
    assign w          = win_reg[0];

    // Collect the upper three bytes of a word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (push)
        begin
            case (byte_lane)
                2'd0:    acc_reg[23:16] <= push_byte;
                2'd1:    acc_reg[15:8]  <= push_byte;
                2'd2:    acc_reg[7:0]   <= push_byte;
                default: acc_reg        <= acc_reg;
            endcase
        end
    end

    // Shift a full word or a schedule word into the window
    always_ff @(posedge clk)
    begin
        if (push && byte_lane == 2'd3)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= {acc_reg, push_byte};
        end
        else if (step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= sched_word;
        end
    end

endmodule

// ----- rtl/sha1_hash_engine.sv -----
// Top level of the SHA-1 hash engine: sequencer, chaining value and result register.
//
//   channel  | dir | payload
//   s_*      | in  | tdata[7:0] data_byte, tuser has_byte, tlast end_of_message
//   m_*      | out | tdata[159:0] digest_word0..digest_word4, word0 in the lowest bits
//
// A byte that completes a block starts a compression: 80 rounds through the single
// round unit, then one chain add. Message end adds the pad bytes, one per cycle
// outside a compression (at most 64), then eight length bytes, one or two
// compressions and one result load. Reset loads the initial hash value; s_tready
// is low while a block is compressed, padded or its digest waits for the result
// register, which holds until m_tready.
module sha1_hash_engine (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // has_byte
    input  logic         s_tlast,   // end_of_message
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata    // digest_word0, digest_word1, ..., digest_word4
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [31:0]          chain_reg [5];
    logic [31:0]          chain_next [5];
    logic [60:0]          count_reg, count_next;
    logic [5:0]           pos_reg, pos_next;
    logic [6:0]           round_reg, round_next;
    logic [2:0]           len_cnt_reg, len_cnt_next;
    logic                 end_pend_reg, end_pend_next;
    logic                 pad_first_reg, pad_first_next;
    logic                 len_done_reg, len_done_next;
    logic                 out_valid_reg, out_valid_next;
    logic [159:0]         digest_reg, digest_next;
    logic [63:0]          len_reg, len_next;
    sha1_pkg::sha1_vars_t vars_reg, vars_next;
    sha1_pkg::sha1_vars_t round_out;
    sha1_pkg::sha1_vars_t chain_vars;

    logic                 push;
    logic [7:0]           push_byte;
    logic                 step;
    logic [31:0]          w;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = digest_reg;

    assign chain_vars = '{a: chain_reg[0], b: chain_reg[1], c: chain_reg[2],
                          d: chain_reg[3], e: chain_reg[4]};

    sha1_sched u_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_byte (push_byte),
        .byte_lane (pos_reg[1:0]),
        .step      (step),
        .w         (w)
    );

    sha1_round u_round (
        .vars_in   (vars_reg),
        .w         (w),
        .round_idx (round_reg),
        .vars_out  (round_out)
    );

    // Sequence byte intake, padding, rounds and result hand-off
    always_comb
    begin
        state_next     = state_reg;
        chain_next     = chain_reg;
        count_next     = count_reg;
        round_next     = round_reg;
        len_cnt_next   = len_cnt_reg;
        end_pend_next  = end_pend_reg;
        pad_first_next = pad_first_reg;
        len_done_next  = len_done_reg;
        digest_next    = digest_reg;
        len_next       = len_reg;
        vars_next      = vars_reg;
        push           = 1'b0;
        push_byte      = '0;
        step           = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    end_pend_next  = s_tlast;
                    pad_first_next = s_tlast;
                    if (s_tuser)
                    begin
                        push       = 1'b1;
                        push_byte  = s_tdata;
                        count_next = count_reg + 61'd1;
                    end
                    if (s_tuser && pos_reg == 6'd63)
                    begin
                        vars_next  = chain_vars;
                        state_next = ST_ROUND;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (pad_first_reg)
                begin
                    push           = 1'b1;
                    push_byte      = sha1_pkg::PAD_MARK;
                    pad_first_next = 1'b0;
                end
                else if (pos_reg == 6'd56)
                begin
                    len_next     = {count_reg, 3'b000};
                    len_cnt_next = '0;
                    state_next   = ST_LEN;
                end
                else
                begin
                    push = 1'b1;
                end
                if (push && pos_reg == 6'd63)
                begin
                    vars_next  = chain_vars;
                    state_next = ST_ROUND;
                end
            end
            ST_LEN:
            begin
                push         = 1'b1;
                push_byte    = len_reg[63:56];
                len_next     = {len_reg[55:0], 8'h00};
                len_cnt_next = len_cnt_reg + 3'd1;
                if (len_cnt_reg == 3'd7)
                begin
                    len_done_next = 1'b1;
                    vars_next     = chain_vars;
                    state_next    = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                step       = 1'b1;
                vars_next  = round_out;
                round_next = round_reg + 7'd1;
                if (round_reg == sha1_pkg::LAST_ROUND)
                begin
                    round_next = '0;
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                chain_next[0] = chain_reg[0] + vars_reg.a;
                chain_next[1] = chain_reg[1] + vars_reg.b;
                chain_next[2] = chain_reg[2] + vars_reg.c;
                chain_next[3] = chain_reg[3] + vars_reg.d;
                chain_next[4] = chain_reg[4] + vars_reg.e;
                if (len_done_reg)
                    state_next = ST_EMIT;
                else if (end_pend_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    digest_next    = {chain_reg[4], chain_reg[3], chain_reg[2],
                                      chain_reg[1], chain_reg[0]};
                    for (int i = 0; i < 5; i++)
                    begin
                        chain_next[i] = sha1_pkg::HASH_IV[i];
                    end
                    count_next     = '0;
                    end_pend_next  = 1'b0;
                    pad_first_next = 1'b0;
                    len_done_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign pos_next = push ? pos_reg + 6'd1 : pos_reg;

    // Hold state, chaining value and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= sha1_pkg::HASH_IV[i];
            end
            count_reg     <= '0;
            pos_reg       <= '0;
            round_reg     <= '0;
            len_cnt_reg   <= '0;
            end_pend_reg  <= 1'b0;
            pad_first_reg <= 1'b0;
            len_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            digest_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            round_reg     <= round_next;
            len_cnt_reg   <= len_cnt_next;
            end_pend_reg  <= end_pend_next;
            pad_first_reg <= pad_first_next;
            len_done_reg  <= len_done_next;
            out_valid_reg <= out_valid_next;
            digest_reg    <= digest_next;
        end
    end

    // Working variables and length shifter
    always_ff @(posedge clk)
    begin
        vars_reg <= vars_next;
        len_reg  <= len_next;
    end

`ifndef SYNTH
    // Round counter never passes the last round
    assert property (@(posedge clk) disable iff (!rst_n) round_reg <= sha1_pkg::LAST_ROUND)
        else $error("round counter out of range");

    // The last round is always followed by the chain add
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == sha1_pkg::LAST_ROUND) |=> state_reg == ST_ADD)
        else $error("chain add did not follow the last round");

    // The final block ends on a block boundary
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> (pos_reg == 6'd0 && len_done_reg))
        else $error("digest emitted off a block boundary");
`endif

endmodule

// ----- test/sha1_digest_checker.sv -----
// Digest checker for the SHA-1 hash engine: tracks both streams and scores every digest.
`timescale 1ns / 100ps

module sha1_digest_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic            s_tready,
    input  logic [7:0]      s_tdata,   // [7:0] data_byte
    input  logic            s_tuser,   // has_byte
    input  logic            s_tlast,   // end_of_message
    input  logic            m_tvalid,
    input  logic            m_tready,
    input  logic [159:0]    m_tdata,   // digest_word0 (lowest bits) .. digest_word4
    output int unsigned     errors,
    output int unsigned     pending
);

    // Shadow hash state
    logic [31:0]  chain [0:4];
    logic [7:0]   block_bytes [0:63];
    logic [60:0]  byte_cnt;

    // Digests still owed by the engine, word0 in the lowest bits
    logic [159:0] digest_q [$];
    int unsigned  err_n;
    int unsigned  digest_idx;

    function automatic logic [31:0] rotl(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Fold the 64 buffered bytes into the chaining value
    function automatic void compress_block();
        logic [31:0] w [0:15];
        logic [31:0] a, b, c, d, e, f, k, t;
        int          r;
        int          s;
        for (r = 0; r < 16; r++)
        begin
            w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2],
                    block_bytes[4*r+3]};
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (r = 0; r < 80; r++)
        begin
            s = r % 16;
            if (r >= 16)
                w[s] = rotl(w[(s + 13) % 16] ^ w[(s + 8) % 16] ^ w[(s + 2) % 16] ^ w[s], 1);
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1_pkg::K_ROUND0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K_ROUND1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1_pkg::K_ROUND2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K_ROUND3;
            end
            t = rotl(a, 5) + f + e + k + w[s];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
        chain[4] = chain[4] + e;
    endfunction

    function automatic void restart_message();
        int i;
        for (i = 0; i < 5; i++)
            chain[i] = sha1_pkg::HASH_IV[i];
        byte_cnt = '0;
    endfunction

    function automatic void take_byte(logic [7:0] data);
        logic [5:0] pos;
        pos = byte_cnt[5:0];
        block_bytes[pos] = data;
        byte_cnt = byte_cnt + 61'd1;
        if (pos == 6'd63)
            compress_block();
    endfunction

    // Pad, append the bit length and queue the digest
    function automatic void finish_message();
        logic [63:0]  bit_len;
        logic [5:0]   pos;
        logic [159:0] digest;
        int           j;
        pos = byte_cnt[5:0];
        block_bytes[pos] = sha1_pkg::PAD_MARK;
        for (j = pos + 1; j < 64; j++)
            block_bytes[j] = 8'h00;
        if (pos >= 6'd56)
        begin
            compress_block();
            for (j = 0; j < 64; j++)
                block_bytes[j] = 8'h00;
        end
        bit_len = {byte_cnt, 3'b000};
        for (j = 0; j < 8; j++)
            block_bytes[56 + j] = bit_len[63 - 8*j -: 8];
        compress_block();
        digest   = {chain[4], chain[3], chain[2], chain[1], chain[0]};
        digest_q = {digest_q, digest};
        restart_message();
    endfunction

    // Update the shadow state on input transfers, score output transfers
    always @(posedge clk or negedge rst_n)
    begin
        logic [159:0] want;
        int           i;
        if (!rst_n)
        begin
            restart_message();
            digest_q.delete();
            err_n      = 0;
            digest_idx = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser)
                    take_byte(s_tdata);
                if (s_tlast)
                    finish_message();
            end
            if (m_tvalid && m_tready)
            begin
                if (digest_q.size() == 0)
                begin
                    if (err_n < 10)
                        $display("unexpected digest %h", m_tdata);
                    err_n++;
                end
                else
                begin
                    want = digest_q.pop_front();
                    for (i = 0; i < 5; i++)
                    begin
                        if (m_tdata[32*i +: 32] !== want[32*i +: 32])
                        begin
                            if (err_n < 10)
                                $display("digest %0d word%0d: expected %h, got %h",
                                         digest_idx, i, want[32*i +: 32],
                                         m_tdata[32*i +: 32]);
                            err_n++;
                        end
                    end
                end
                digest_idx++;
            end
            errors  <= err_n;
            pending <= digest_q.size();
        end
    end

endmodule

// ----- test/sha1_hash_engine_tb.sv -----
// Testbench top for the SHA-1 hash engine: clock, reset, message traffic and verdict.
`timescale 1ns / 100ps

module sha1_hash_engine_tb;

    localparam int MIN_ITEMS    = 420;
    localparam int MIN_MESSAGES = 8;
    localparam int LONG_HOLD    = 3000;
    localparam int TAIL_CYCLES  = 400;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;

    int unsigned  errors;
    int unsigned  pending;
    int unsigned  byte_items;
    int unsigned  messages;
    bit           quiet;
    bit           hold_req;

    sha1_hash_engine i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sha1_digest_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Abort a hung run
    initial
    begin
        #8_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Offer one transfer and hold it until the engine takes it
    task automatic send_item(logic [7:0] data, logic has, logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has;
        s_tlast  <= last;
        if (has || last)
            byte_items++;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Drop valid for a random burst now and then
    task automatic idle_gap();
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // Send a message of len bytes; split_end closes it with a byte-less end transfer
    task automatic send_message(int len, bit split_end);
        int i;
        for (i = 0; i < len; i++)
        begin
            idle_gap();
            if ($urandom_range(0, 7) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, (i == len - 1) && !split_end);
        end
        if (split_end || len == 0)
        begin
            idle_gap();
            send_item(8'($urandom), 1'b0, 1'b1);
        end
        messages++;
    endtask

    // Stop sending until every owed digest has left
    task automatic drain_digests();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Output backpressure: random stalls, one long hold on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    // Stimulus
    initial
    begin
        int len;
        int pick;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tuser    = 1'b0;
        s_tlast    = 1'b0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        byte_items = 0;
        messages   = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Empty message right after reset
        send_item(8'h00, 1'b0, 1'b1);
        // Ignored transfer with every data bit set
        send_item(8'hff, 1'b0, 1'b0);
        // "abc", end carried on the last byte
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // One zero byte, closed by a separate end transfer with junk data
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b1);
        // One byte of all ones with the end mark
        send_item(8'hff, 1'b1, 1'b1);
        // Ignored transfer inside a message
        send_item(8'h5a, 1'b1, 1'b0);
        send_item(8'ha5, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);
        // Two more empty messages back to back
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h7f, 1'b0, 1'b1);
        drain_digests();

        // Random traffic; start with a long output hold so the engine backs up
        hold_req = 1'b1;
        messages = 0;
        while (byte_items < MIN_ITEMS || messages < MIN_MESSAGES)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                len = $urandom_range(0, 12);
            else if (pick < 8)
                len = $urandom_range(52, 68);
            else if (pick < 9)
                len = $urandom_range(116, 132);
            else
                len = $urandom_range(13, 200);
            send_message(len, $urandom_range(0, 2) == 0);
        end

        // Final stretch at full rate on both sides
        quiet = 1'b1;
        repeat (4)
            send_message($urandom_range(0, 40), 1'($urandom_range(0, 1)));

        drain_digests();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
